@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertion helpers used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define GSTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define GSTC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/gstc_pkg.sv @@
// ---------------------------------------------------------------------------
// gstc_pkg
// widths, register codes, reset values and helper functions of the
// stick and trigger conditioner
// ---------------------------------------------------------------------------
package gstc_pkg;

    localparam int STICK_W   = 16;
    localparam int PULL_W    = 8;
    localparam int MAG_W     = STICK_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam int S_DATA_W  = 4 * STICK_W + 2 * PULL_W;
    localparam int M_DATA_W  = 6 * STICK_W;

    // iteration counts of the shared subtractor and the multiplier
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 17;
    localparam int POW_STEPS  = 4;
    localparam int CNT_W      = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR  = 2'd2;

    localparam logic [STICK_W-1:0] LEFT_DZ_RST  = 16'd7849;
    localparam logic [STICK_W-1:0] RIGHT_DZ_RST = 16'd8689;
    localparam logic [PULL_W-1:0]  TRIG_THR_RST = 8'd30;

    localparam logic [STICK_W-1:0]   DIR_MAX    = 16'h7FFF;
    localparam logic [2*MAG_W-1:0]   ROUND_HALF = 34'd16384;

    // magnitude of a two's complement stick value
    function automatic logic [MAG_W-1:0] stick_mag(input logic [STICK_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {v[STICK_W-1], v};
        return v[STICK_W-1] ? (~ext + 1'b1) : ext;
    endfunction

    // apply sign, saturate positive values at +32767
    function automatic logic [STICK_W-1:0] sat_dir(input logic [MAG_W-1:0] mag,
                                                   input logic neg);
        logic [MAG_W-1:0] negm;
        negm = ~mag + 1'b1;
        if (neg) begin
            return negm[STICK_W-1:0];
        end else if (mag > {1'b0, DIR_MAX}) begin
            return DIR_MAX;
        end else begin
            return mag[STICK_W-1:0];
        end
    endfunction

    // trig * 257 above threshold
    function automatic logic [STICK_W-1:0] trig_level(input logic [PULL_W-1:0] p,
                                                      input logic [PULL_W-1:0] thr);
        return (p > thr) ? {p, p} : '0;
    endfunction

endpackage

@@ sv/gamepad_stick_trigger_conditioner_unit.sv @@
// ---------------------------------------------------------------------------
// gamepad stick and trigger conditioner
// One controller sample in, one conditioned sample out. Each stick whose
// radius is at or below its deadzone reads zero; otherwise it yields its
// unit direction x/r, y/r in Q1.15 (ties rounded away from zero, positive
// saturating at 32767), and the right stick components are raised to the
// fifth power. Triggers above the threshold give trig*257 (Q0.16), else 0.
// A sample with pad_present low repeats the previous outputs with link_ok 0.
// Timing: one sample at a time. An absent-pad sample goes from the idle
// state straight to the output register. A present sample takes, per
// stick, the squared radius and deadzone compare, then per component a
// 33-step restoring divide and a 17-step square root that run on one
// shared 34-bit subtractor; the right stick adds 4 passes through the
// shared 17x17 multiplier per component.
// tready is high only while the sequencer is idle; a finished result sits
// in the output register and does not block the next sample.
// ---------------------------------------------------------------------------
module gamepad_stick_trigger_conditioner_unit
    import gstc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // sample input
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // left_x, left_y, right_x, right_y, left_pull, right_pull
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // pad_present
    input  logic                  i_s_axis_tuser,
    // conditioned output
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // left_dir_x, left_dir_y, right_dir_x, right_dir_y, left_level, right_level
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    // link_ok
    output logic                  o_m_axis_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,     // r_s = x*x
        ST_SQY,     // r_s += y*y
        ST_SQD,     // r_dz2 = deadzone^2
        ST_CMP,     // outside deadzone?
        ST_SQA,     // dividend a*a for this component
        ST_DIV,     // a*a*2^32 / s, one quotient bit per cycle
        ST_SQRT,    // isqrt of quotient, one root bit per cycle
        ST_FIN,     // round and saturate the direction
        ST_POW,     // t = (t*|d| + half) >> 15
        ST_POWFIN,  // restore sign of the fifth power
        ST_LVL,     // trigger levels
        ST_DONE     // hand the sample to the output register
    } t_state;

    t_state r_state;

    // configuration
    logic [STICK_W-1:0] r_left_dz;
    logic [STICK_W-1:0] r_right_dz;
    logic [PULL_W-1:0]  r_trig_thr;

    // latched sample
    logic signed [STICK_W-1:0] r_in_lx, r_in_ly, r_in_rx, r_in_ry;
    logic [PULL_W-1:0]         r_in_lp, r_in_rp;

    // sequencer
    logic             r_side;   // 0 left stick, 1 right stick
    logic             r_comp;   // 0 x component, 1 y component
    logic [CNT_W-1:0] r_cnt;

    // datapath
    logic [31:0]        r_s;
    logic [31:0]        r_dz2;
    logic [2*MAG_W-1:0] r_rem;
    logic [2*MAG_W-1:0] r_q;
    logic [MAG_W-1:0]   r_root;
    logic               r_neg;
    logic [MAG_W-1:0]   r_t;
    logic [MAG_W-1:0]   r_pa;
    logic               r_dneg;

    // held outputs
    logic [STICK_W-1:0] r_hold_lx, r_hold_ly, r_hold_rx, r_hold_ry;
    logic [STICK_W-1:0] r_hold_ll, r_hold_rl;
    logic               r_link;

    // output register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_user;

    // current stick and component selection
    logic [STICK_W-1:0] w_x_sel, w_y_sel, w_c_sel, w_dz_sel;
    assign w_x_sel  = r_side ? r_in_rx : r_in_lx;
    assign w_y_sel  = r_side ? r_in_ry : r_in_ly;
    assign w_c_sel  = r_comp ? w_y_sel : w_x_sel;
    assign w_dz_sel = r_side ? r_right_dz : r_left_dz;

    // shared multiplier
    logic [MAG_W-1:0]   w_mul_a, w_mul_b;
    logic [2*MAG_W-1:0] w_prod;
    logic [2*MAG_W-1:0] w_pow_sum;

    always_comb begin
        unique case (r_state)
            ST_SQX: begin
                w_mul_a = stick_mag(w_x_sel);
                w_mul_b = stick_mag(w_x_sel);
            end
            ST_SQY: begin
                w_mul_a = stick_mag(w_y_sel);
                w_mul_b = stick_mag(w_y_sel);
            end
            ST_SQD: begin
                w_mul_a = {1'b0, w_dz_sel};
                w_mul_b = {1'b0, w_dz_sel};
            end
            ST_SQA: begin
                w_mul_a = stick_mag(w_c_sel);
                w_mul_b = stick_mag(w_c_sel);
            end
            ST_POW: begin
                w_mul_a = r_t;
                w_mul_b = r_pa;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_pow_sum = w_prod + ROUND_HALF;

    // shared subtractor: divide step or square root step
    logic [2*MAG_W-1:0] w_sub_a, w_sub_b;
    logic [2*MAG_W:0]   w_diff;
    logic               w_ge;
    logic [2*MAG_W-1:0] w_sub_sel;

    always_comb begin
        if (r_state == ST_SQRT) begin
            // bring down the next pair of radicand bits, trial = 4*root + 1
            w_sub_a = {r_rem[2*MAG_W-3:0], r_q[2*MAG_W-1:2*MAG_W-2]};
            w_sub_b = {{(MAG_W-2){1'b0}}, r_root, 2'b01};
        end else begin
            w_sub_a = r_rem;
            w_sub_b = {2'b00, r_s};
        end
    end

    assign w_diff    = {1'b0, w_sub_a} - {1'b0, w_sub_b};
    assign w_ge      = ~w_diff[2*MAG_W];
    assign w_sub_sel = w_ge ? w_diff[2*MAG_W-1:0] : w_sub_a;

    // direction from the root: m = (root + 1) >> 1
    logic [MAG_W:0]     w_m_sum;
    logic [STICK_W-1:0] w_dir;
    logic [STICK_W-1:0] w_pow_dir;
    assign w_m_sum   = {1'b0, r_root} + {{MAG_W{1'b0}}, 1'b1};
    assign w_dir     = sat_dir(w_m_sum[MAG_W:1], r_neg);
    assign w_pow_dir = sat_dir(r_t, r_dneg);

    // where to go once a component is finished
    logic   w_last_comp;
    t_state w_after_stick;
    assign w_last_comp   = r_comp;
    assign w_after_stick = r_side ? ST_LVL : ST_SQX;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_dz  <= LEFT_DZ_RST;
            r_right_dz <= RIGHT_DZ_RST;
            r_trig_thr <= TRIG_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT_DZ:  r_left_dz  <= i_cfg_data;
                CFG_RIGHT_DZ: r_right_dz <= i_cfg_data;
                CFG_TRIG_THR: r_trig_thr <= i_cfg_data[PULL_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // sample latch, payload only
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_lx <= i_s_axis_tdata[0*STICK_W +: STICK_W];
            r_in_ly <= i_s_axis_tdata[1*STICK_W +: STICK_W];
            r_in_rx <= i_s_axis_tdata[2*STICK_W +: STICK_W];
            r_in_ry <= i_s_axis_tdata[3*STICK_W +: STICK_W];
            r_in_lp <= i_s_axis_tdata[4*STICK_W +: PULL_W];
            r_in_rp <= i_s_axis_tdata[4*STICK_W+PULL_W +: PULL_W];
        end
    end

    // sequencer, datapath and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= 1'b0;
            r_comp      <= 1'b0;
            r_cnt       <= '0;
            r_hold_lx   <= '0;
            r_hold_ly   <= '0;
            r_hold_rx   <= '0;
            r_hold_ry   <= '0;
            r_hold_ll   <= '0;
            r_hold_rl   <= '0;
            r_link      <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_user  <= 1'b0;
            r_out_data  <= '0;
        end else begin
            // output transaction taken, unless a new one is loaded right away
            if (r_out_valid && i_m_axis_tready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_link <= i_s_axis_tuser;
                        r_side <= 1'b0;
                        r_comp <= 1'b0;
                        // absent pad: held values are repeated as they are
                        r_state <= i_s_axis_tuser ? ST_SQX : ST_DONE;
                    end
                end
                ST_SQX: begin
                    r_s     <= w_prod[31:0];
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_s     <= r_s + w_prod[31:0];
                    r_state <= ST_SQD;
                end
                ST_SQD: begin
                    r_dz2   <= w_prod[31:0];
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (r_s > r_dz2) begin
                        r_comp  <= 1'b0;
                        r_state <= ST_SQA;
                    end else begin
                        // inside the deadzone, stick reads zero
                        if (r_side) begin
                            r_hold_rx <= '0;
                            r_hold_ry <= '0;
                        end else begin
                            r_hold_lx <= '0;
                            r_hold_ly <= '0;
                        end
                        r_side  <= 1'b1;
                        r_state <= w_after_stick;
                    end
                end
                ST_SQA: begin
                    r_rem   <= {2'b00, w_prod[31:0]};
                    r_q     <= '0;
                    r_neg   <= w_c_sel[STICK_W-1];
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_q <= {r_q[2*MAG_W-2:0], w_ge};
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_rem <= {w_sub_sel[2*MAG_W-2:0], 1'b0};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_rem  <= w_sub_sel;
                    r_root <= {r_root[MAG_W-2:0], w_ge};
                    r_q    <= {r_q[2*MAG_W-3:0], 2'b00};
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_FIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_FIN: begin
                    if (r_side) begin
                        // right stick goes on to the fifth power
                        r_pa    <= stick_mag(w_dir);
                        r_t     <= stick_mag(w_dir);
                        r_dneg  <= w_dir[STICK_W-1];
                        r_cnt   <= '0;
                        r_state <= ST_POW;
                    end else begin
                        if (r_comp) begin
                            r_hold_ly <= w_dir;
                        end else begin
                            r_hold_lx <= w_dir;
                        end
                        r_comp <= 1'b1;
                        if (w_last_comp) begin
                            r_side  <= 1'b1;
                            r_state <= w_after_stick;
                        end else begin
                            r_state <= ST_SQA;
                        end
                    end
                end
                ST_POW: begin
                    r_t <= w_pow_sum[MAG_W+14:15];
                    if (r_cnt == CNT_W'(POW_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_POWFIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_POWFIN: begin
                    if (r_comp) begin
                        r_hold_ry <= w_pow_dir;
                    end else begin
                        r_hold_rx <= w_pow_dir;
                    end
                    r_comp  <= 1'b1;
                    r_state <= w_last_comp ? ST_LVL : ST_SQA;
                end
                ST_LVL: begin
                    r_hold_ll <= trig_level(r_in_lp, r_trig_thr);
                    r_hold_rl <= trig_level(r_in_rp, r_trig_thr);
                    r_state   <= ST_DONE;
                end
                ST_DONE: begin
                    // wait for a free output register
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_link;
                        r_out_data  <= {r_hold_rl, r_hold_ll, r_hold_ry,
                                        r_hold_rx, r_hold_ly, r_hold_lx};
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ sv/gstc_checker.sv @@
// ---------------------------------------------------------------------------
// gstc_checker
// port level checks of the stick and trigger conditioner
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gstc_checker
    import gstc_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                i_s_tready,
    input logic                i_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] i_m_tdata,
    input logic                i_m_tuser
);

    // last output transaction delivered
    logic [M_DATA_W-1:0] r_last_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_data <= '0;
        end else if (i_m_tvalid && i_m_tready) begin
            r_last_data <= i_m_tdata;
        end
    end

    `GSTC_ASSERT_ALWAYS(a_rst_no_out, i_clk, !i_rst_n |=> !i_m_tvalid, "output valid after reset")
    `GSTC_ASSERT(a_busy_after_in, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready, "ready right after input")
    `GSTC_ASSERT(a_link_down_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tuser |-> i_m_tdata == r_last_data, "link down output differs from last")
    `GSTC_ASSERT(a_level_form, i_clk, i_rst_n, i_m_tvalid |-> (i_m_tdata[71:64] == i_m_tdata[79:72]) && (i_m_tdata[87:80] == i_m_tdata[95:88]), "trigger level not a multiple of 257")
    `GSTC_ASSERT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata), "stalled output changed")

endmodule

bind gamepad_stick_trigger_conditioner_unit gstc_checker u_gstc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// stick and trigger conditioner testbench
// Drives controller samples over the input stream and checks every
// conditioned output against a bit-exact predictor kept in the bench:
// deadzone compare on the squared radius, rounded unit direction, fifth
// power on the right stick, trigger levels and the held outputs of absent
// samples. A short directed table comes first, then random samples under
// several deadzone and threshold settings, with random stalls on both sides.
// ---------------------------------------------------------------------------
module testbench;
    import gstc_pkg::*;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASES        = 8;
    localparam int PHASE_SAMPLES = 210;
    localparam int REPORT_MAX    = 10;
    localparam int DRAIN_CYCLES  = 240;

    // one controller sample, {tuser, tdata} from the top bit down
    typedef struct packed {
        logic        pad_present;
        logic [7:0]  right_pull;
        logic [7:0]  left_pull;
        logic [15:0] right_y;
        logic [15:0] right_x;
        logic [15:0] left_y;
        logic [15:0] left_x;
    } pad_sample_t;

    // one conditioned output, {tuser, tdata} from the top bit down
    typedef struct packed {
        logic        link_ok;
        logic [15:0] right_level;
        logic [15:0] left_level;
        logic [15:0] right_dir_y;
        logic [15:0] right_dir_x;
        logic [15:0] left_dir_y;
        logic [15:0] left_dir_x;
    } conditioned_t;

    typedef struct {
        pad_sample_t  smp;
        bit           typed;
        conditioned_t want;
    } directed_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_DATA_W-1:0]  i_s_axis_tdata;
    logic                 i_s_axis_tuser;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_DATA_W-1:0]  o_m_axis_tdata;
    logic                 o_m_axis_tuser;

    gamepad_stick_trigger_conditioner_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // predictor copy of the registers and the held outputs
    int unsigned  left_zone;
    int unsigned  right_zone;
    logic [7:0]   pull_threshold;
    conditioned_t held_out;

    conditioned_t  pending_outputs[$];
    directed_row_t directed_rows[$];

    int  cycle_count;
    int  mismatch_count;
    int  outputs_checked;
    int  samples_sent;
    int  absent_sent;
    int  left_inside;
    int  right_inside;
    bit  steady_flow;

    logic [96:0] want_bits;
    logic [96:0] got_bits;
    string       field_name[7] = '{"left_dir_x", "left_dir_y", "right_dir_x",
                                   "right_dir_y", "left_level", "right_level", "link_ok"};

    // 20 unit clock period
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run limit, catches a hung handshake
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d outputs still expected",
                     cycle_count, pending_outputs.size());
            $display("testbench failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------------

    // sign applied last; only positive magnitudes saturate, -32768 survives
    function automatic logic [15:0] apply_sign(longint unsigned mag, bit neg);
        if (neg)
            return 16'(~mag + 64'd1);
        else if (mag > 64'd32767)
            return 16'h7FFF;
        else
            return 16'(mag);
    endfunction

    function automatic longint unsigned radius_sq(logic [15:0] x, logic [15:0] y);
        longint sx;
        longint sy;
        sx = $signed(x);
        sy = $signed(y);
        return longint'(sx * sx + sy * sy);
    endfunction

    // round(|c| * 32768 / sqrt(rsq)), ties away from zero, searched exactly:
    // largest m with (2m-1)^2 * rsq <= c^2 * 2^32
    function automatic logic [15:0] unit_direction(logic [15:0] c, longint unsigned rsq);
        longint unsigned mag;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned odd;
        logic [127:0]    bound;
        logic [127:0]    lhs;
        mag   = c[15] ? (64'd65536 - 64'(c)) : 64'(c);
        bound = 128'(mag * mag) << 32;
        lo    = 0;
        hi    = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            odd = 2 * mid - 1;
            lhs = 128'(odd) * 128'(odd) * 128'(rsq);
            if (lhs <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return apply_sign(lo, c[15]);
    endfunction

    // four rounded Q1.15 multiplies on the magnitude, then the sign
    function automatic logic [15:0] fifth_power(logic [15:0] d);
        longint unsigned mag;
        longint unsigned acc;
        mag = d[15] ? (64'd65536 - 64'(d)) : 64'(d);
        acc = mag;
        repeat (4) acc = (acc * mag + 64'd16384) >> 15;
        return apply_sign(acc, d[15]);
    endfunction

    // trig/255 in Q0.16 is trig*257, strictly above the threshold only
    function automatic logic [15:0] trigger_level(logic [7:0] pull, logic [7:0] thr);
        return (pull > thr) ? 16'(pull * 257) : 16'd0;
    endfunction

    task automatic condition_sample(input pad_sample_t smp, output conditioned_t res);
        longint unsigned rsq;
        if (smp.pad_present) begin
            rsq = radius_sq(smp.left_x, smp.left_y);
            if (rsq > 64'(left_zone) * 64'(left_zone)) begin
                held_out.left_dir_x = unit_direction(smp.left_x, rsq);
                held_out.left_dir_y = unit_direction(smp.left_y, rsq);
            end else begin
                held_out.left_dir_x = '0;
                held_out.left_dir_y = '0;
                left_inside++;
            end
            rsq = radius_sq(smp.right_x, smp.right_y);
            if (rsq > 64'(right_zone) * 64'(right_zone)) begin
                held_out.right_dir_x = fifth_power(unit_direction(smp.right_x, rsq));
                held_out.right_dir_y = fifth_power(unit_direction(smp.right_y, rsq));
            end else begin
                held_out.right_dir_x = '0;
                held_out.right_dir_y = '0;
                right_inside++;
            end
            held_out.left_level  = trigger_level(smp.left_pull, pull_threshold);
            held_out.right_level = trigger_level(smp.right_pull, pull_threshold);
        end
        // an absent pad repeats the held values with the link flag low
        res         = held_out;
        res.link_ok = smp.pad_present;
    endtask

    // ---------------------------------------------------------------------
    // output side: random backpressure and the checker
    // ---------------------------------------------------------------------

    always @(negedge i_clk) begin
        i_m_axis_tready = steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    // sampled at the rising edge, before the block's registers move
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_bits = {o_m_axis_tuser, o_m_axis_tdata};
            if (pending_outputs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("output transaction with nothing expected: %h", got_bits);
            end else begin
                want_bits = pending_outputs.pop_front();
                outputs_checked++;
                for (int k = 0; k < 7; k++) begin
                    if ((k < 6 && want_bits[16*k +: 16] !== got_bits[16*k +: 16]) ||
                        (k == 6 && want_bits[96] !== got_bits[96])) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("output %0d, %s: expected %h, got %h",
                                     outputs_checked, field_name[k],
                                     (k < 6) ? want_bits[16*k +: 16] : 16'(want_bits[96]),
                                     (k < 6) ? got_bits[16*k +: 16] : 16'(got_bits[96]));
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------------

    // register write, called on a falling edge while the block is idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        case (idx)
            CFG_LEFT_DZ:  left_zone      = value;
            CFG_RIGHT_DZ: right_zone     = value;
            CFG_TRIG_THR: pull_threshold = value[7:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // one input transaction; the expectation is queued when it is accepted
    task automatic deliver(pad_sample_t smp, bit typed, conditioned_t want);
        conditioned_t predicted;
        while (!steady_flow && $urandom_range(0, 99) < 34) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        {i_s_axis_tuser, i_s_axis_tdata} = smp;
        do @(posedge i_clk); while (!o_s_axis_tready);
        condition_sample(smp, predicted);
        // typed rows still run the predictor so the held state follows along
        pending_outputs.push_back(typed ? want : predicted);
        samples_sent++;
        if (!smp.pad_present)
            absent_sent++;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // sender holds off until every queued output has come back
    task automatic wait_for_outputs();
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic add_row(int lx, int ly, int rx, int ry, int lp, int rp, bit pad,
                           bit typed, conditioned_t want);
        directed_row_t row;
        row.smp   = {pad, 8'(rp), 8'(lp), 16'(ry), 16'(rx), 16'(ly), 16'(lx)};
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // stick values on and around the deadzone edge and at full scale
    function automatic logic [15:0] boundary_value(int unsigned zone);
        int v;
        case ($urandom_range(0, 8))
            0:       v = 0;
            1:       v = 1;
            2:       v = -1;
            3:       v = zone;
            4:       v = zone + 1;
            5:       v = -int'(zone);
            6:       v = -int'(zone) - 1;
            7:       v = 32767;
            default: v = -32768;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    task automatic random_stick(int unsigned zone, output logic [15:0] x,
                                output logic [15:0] y);
        int          span;
        logic [15:0] swap;
        span = (zone + 64 > 32767) ? 32767 : zone + 64;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                x = 16'($urandom);
                y = 16'($urandom);
            end
            4, 5: begin
                // close to the deadzone circle
                x = 16'(int'($urandom_range(0, 2 * span)) - span);
                y = 16'(int'($urandom_range(0, 2 * span)) - span);
            end
            6, 7: begin
                x = boundary_value(zone);
                y = boundary_value(zone);
            end
            default: begin
                // on an axis, where the radius can hit the deadzone edge exactly
                x = $urandom_range(0, 1) ? 16'($urandom) : boundary_value(zone);
                y = '0;
                if ($urandom_range(0, 1)) begin
                    swap = x;
                    x    = y;
                    y    = swap;
                end
            end
        endcase
    endtask

    function automatic logic [7:0] random_pull(logic [7:0] thr);
        int v;
        if ($urandom_range(0, 1))
            return 8'($urandom);
        // around the threshold
        v = int'(thr) + int'($urandom_range(0, 4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return 8'(v);
    endfunction

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial begin
        pad_sample_t smp;
        logic [15:0] rand_x;
        logic [15:0] rand_y;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LEFT_DZ;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        i_m_axis_tready = 1'b0;
        steady_flow     = 1'b0;
        left_zone       = LEFT_DZ_RST;
        right_zone      = RIGHT_DZ_RST;
        pull_threshold  = TRIG_THR_RST;
        held_out        = '0;

        // directed rows; want is {link, right_level, left_level,
        // right_dir_y, right_dir_x, left_dir_y, left_dir_x}
        // absent pad straight after reset gives zeros
        add_row(-1, -1, -1, -1, 255, 255, 1'b0, 1'b1, '0);
        // centered sticks, released triggers
        add_row(0, 0, 0, 0, 0, 0, 1'b1, 1'b1, {1'b1, 96'd0});
        // full right on the left stick saturates, full triggers
        add_row(32767, 0, 0, 0, 255, 255, 1'b1, 1'b1,
                {1'b1, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd32767});
        // full negative keeps -32768 through the fifth power;
        // trigger at the threshold reads zero, one above it reads
        add_row(0, -32768, -32768, 0, 30, 31, 1'b1, 1'b1,
                {1'b1, 16'd7967, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0});
        // absent pad repeats the previous output
        add_row(12345, -12345, 777, -777, 200, 1, 1'b0, 1'b1,
                {1'b0, 16'd7967, 16'd0, 16'd0, 16'h8000, 16'h8000, 16'd0});
        // deadzone edges: radius equal reads zero, one more does not
        add_row(7849, 0, 0, 8689, 31, 30, 1'b1, 1'b0, '0);
        add_row(-7850, 0, 0, -8690, 29, 32, 1'b1, 1'b0, '0);
        add_row(0, 0, 0, -8689, 0, 0, 1'b1, 1'b0, '0);
        // diagonals at full scale, then other mixed samples
        add_row(32767, 32767, 32767, 32767, 128, 127, 1'b1, 1'b0, '0);
        add_row(-32768, -32768, -32768, 32767, 255, 0, 1'b1, 1'b0, '0);
        add_row(-32768, 32767, 32767, -32768, 0, 255, 1'b1, 1'b0, '0);
        add_row(1, -1, -1, 1, 100, 100, 1'b1, 1'b0, '0);
        add_row(12345, -23456, -30000, 20000, 128, 29, 1'b1, 1'b0, '0);
        add_row(100, -32768, 5, 32767, 31, 30, 1'b1, 1'b0, '0);
        add_row(0, 32767, 32767, 0, 64, 192, 1'b1, 1'b0, '0);
        add_row(-23170, -23170, -23170, 23170, 85, 170, 1'b1, 1'b0, '0);
        add_row(-1, -1, -1, -1, 255, 255, 1'b0, 1'b0, '0);

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r])
            deliver(directed_rows[r].smp, directed_rows[r].typed, directed_rows[r].want);

        // random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_for_outputs();
                case (phase)
                    1: begin
                        write_register(CFG_LEFT_DZ, 16'd0);
                        write_register(CFG_RIGHT_DZ, 16'd0);
                        write_register(CFG_TRIG_THR, 16'd0);
                    end
                    2: begin
                        write_register(CFG_LEFT_DZ, 16'd46341);
                        write_register(CFG_RIGHT_DZ, 16'd46341);
                        write_register(CFG_TRIG_THR, 16'd255);
                    end
                    3: begin
                        // beyond any reachable radius on the left
                        write_register(CFG_LEFT_DZ, 16'hFFFF);
                        write_register(CFG_RIGHT_DZ, 16'd1);
                        write_register(CFG_TRIG_THR, 16'd128);
                    end
                    default: begin
                        write_register(CFG_LEFT_DZ, 16'($urandom_range(0, 46341)));
                        write_register(CFG_RIGHT_DZ, 16'($urandom_range(0, 46341)));
                        write_register(CFG_TRIG_THR, 16'($urandom_range(0, 255)));
                    end
                endcase
            end
            // one phase runs with no stalls on either side
            steady_flow = (phase == 5);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                random_stick(left_zone, rand_x, rand_y);
                smp.left_x = rand_x;
                smp.left_y = rand_y;
                random_stick(right_zone, rand_x, rand_y);
                smp.right_x     = rand_x;
                smp.right_y     = rand_y;
                smp.left_pull   = random_pull(pull_threshold);
                smp.right_pull  = random_pull(pull_threshold);
                smp.pad_present = ($urandom_range(0, 99) < 85);
                deliver(smp, 1'b0, '0);
            end
        end
        steady_flow = 1'b0;

        // drain, then give a late or extra output time to show up
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d samples (%0d with the pad absent) under %0d register settings, %0d outputs checked",
                 samples_sent, absent_sent, PHASES, outputs_checked);
        $display("sticks inside the deadzone: %0d left, %0d right; %0d mismatches",
                 left_inside, right_inside, mismatch_count);
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/gstc_pkg.sv
sv/gamepad_stick_trigger_conditioner_unit.sv
sv/gstc_checker.sv
tb/sv/testbench.sv
